### rtl/cpp_pkg.sv
// cpp_pkg: shared types and constants for the perspective projection block
// no dependencies
package cpp_pkg;

    localparam int QUOT_BITS = 33;

    typedef enum logic [3:0] {
        REG_CAM_POS_X     = 4'd0,
        REG_CAM_POS_Y     = 4'd1,
        REG_CAM_POS_Z     = 4'd2,
        REG_VIEW_DISTANCE = 4'd3,
        REG_COS_YAW       = 4'd4,
        REG_SIN_YAW       = 4'd5,
        REG_COS_PITCH     = 4'd6,
        REG_SIN_PITCH     = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        u_neg;
        logic        v_neg;
        logic        u_zero;
        logic        v_zero;
        logic        s_neg;
        logic        s_zero;
        logic        d_zero;
        logic [31:0] depth;
        logic        depth_ovf;
    } side_t;

endpackage

### rtl/cpp_geom.sv
// cpp_geom: eight-stage front end, view-space dot products, magnitudes,
// depth and the d*|numerator| products; uses cpp_pkg
module cpp_geom #(
    parameter int TRIG_FRAC_BITS = 14,
    localparam int HW = 50 - TRIG_FRAC_BITS,
    localparam int QW = 16 + HW,
    localparam int SW = QW + 1 - TRIG_FRAC_BITS,
    localparam int NW = 31 + SW,
    localparam int LO_W = SW / 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [31:0]   world_x,
    input  logic signed [31:0]   world_y,
    input  logic signed [31:0]   world_z,
    input  logic signed [31:0]   cam_x,
    input  logic signed [31:0]   cam_y,
    input  logic signed [31:0]   cam_z,
    input  logic [30:0]          view_dist,
    input  logic signed [15:0]   cy,
    input  logic signed [15:0]   sy,
    input  logic signed [15:0]   cp,
    input  logic signed [15:0]   sp,
    output logic                 out_valid,
    output logic [NW-1:0]        num_u,
    output logic [NW-1:0]        num_v,
    output logic [SW-1:0]        den,
    output cpp_pkg::side_t       side
);

    logic [7:0] v_reg;

    logic signed [32:0]   rx_reg, ry_reg, rz_reg;
    logic signed [48:0]   pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [32:0]   rz2_reg;
    logic signed [HW-1:0] h_reg, a3_reg;
    logic signed [32:0]   rz3_reg;
    logic signed [QW-1:0] pch_reg, psh_reg;
    logic signed [48:0]   psr_reg, pcr_reg;
    logic signed [HW-1:0] a4_reg;
    logic signed [SW-1:0] s5_reg, b5_reg;
    logic signed [HW-1:0] a5_reg;
    logic [SW-1:0]        mu_reg, mv_reg, ms_reg;
    cpp_pkg::side_t       side6_reg, side7_reg, side8_reg;
    logic [30+LO_W:0]     pul_reg, pvl_reg;
    logic [30+SW-LO_W:0]  puh_reg, pvh_reg;
    logic [SW-1:0]        ms7_reg, ms8_reg;
    logic [NW-1:0]        num_u_reg, num_v_reg;

    logic signed [49:0]   hsum, asum;
    logic signed [QW:0]   ssum, bsum;
    logic signed [SW-1:0] a_ext, a_neg, b_neg, s_neg;
    logic signed [SW:0]   dep_diff;
    logic [SW-31:0]       dep_hi;
    logic                 dep_ovf;
    cpp_pkg::side_t       side6_next;

    always_comb
    begin
        hsum = 50'(pxc_reg) + 50'(pys_reg);
        asum = 50'(pyc_reg) - 50'(pxs_reg);
        ssum = (QW+1)'(pch_reg) + (QW+1)'(psr_reg);
        bsum = (QW+1)'(pcr_reg) - (QW+1)'(psh_reg);
        a_ext = SW'(a5_reg);
        a_neg = -a_ext;
        b_neg = -b5_reg;
        s_neg = -s5_reg;
        dep_diff = (SW+1)'(s5_reg) - (SW+1)'(view_dist);
        dep_hi = dep_diff[SW:31];
        dep_ovf = !((&dep_hi) || !(|dep_hi));
        side6_next.u_neg = a_ext[SW-1];
        side6_next.v_neg = b5_reg[SW-1];
        side6_next.u_zero = (a_ext == '0);
        side6_next.v_zero = (b5_reg == '0);
        side6_next.s_neg = s5_reg[SW-1];
        side6_next.s_zero = (s5_reg == '0);
        side6_next.d_zero = (view_dist == '0);
        side6_next.depth_ovf = dep_ovf;
        if (dep_ovf)
        begin
            side6_next.depth = dep_diff[SW] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        else
        begin
            side6_next.depth = dep_diff[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= 33'(world_x) - 33'(cam_x);
            ry_reg <= 33'(world_y) - 33'(cam_y);
            rz_reg <= 33'(world_z) - 33'(cam_z);

            pxc_reg <= rx_reg * cy;
            pys_reg <= ry_reg * sy;
            pyc_reg <= ry_reg * cy;
            pxs_reg <= rx_reg * sy;
            rz2_reg <= rz_reg;

            h_reg <= hsum[49:TRIG_FRAC_BITS];
            a3_reg <= asum[49:TRIG_FRAC_BITS];
            rz3_reg <= rz2_reg;

            pch_reg <= cp * h_reg;
            psh_reg <= sp * h_reg;
            psr_reg <= sp * rz3_reg;
            pcr_reg <= cp * rz3_reg;
            a4_reg <= a3_reg;

            s5_reg <= ssum[QW:TRIG_FRAC_BITS];
            b5_reg <= bsum[QW:TRIG_FRAC_BITS];
            a5_reg <= a4_reg;

            mu_reg <= a_ext[SW-1] ? a_neg : a_ext;
            mv_reg <= b5_reg[SW-1] ? b_neg : b5_reg;
            ms_reg <= s5_reg[SW-1] ? s_neg : s5_reg;
            side6_reg <= side6_next;

            pul_reg <= view_dist * mu_reg[LO_W-1:0];
            puh_reg <= view_dist * mu_reg[SW-1:LO_W];
            pvl_reg <= view_dist * mv_reg[LO_W-1:0];
            pvh_reg <= view_dist * mv_reg[SW-1:LO_W];
            ms7_reg <= ms_reg;
            side7_reg <= side6_reg;

            num_u_reg <= NW'(pul_reg) + (NW'(puh_reg) << LO_W);
            num_v_reg <= NW'(pvl_reg) + (NW'(pvh_reg) << LO_W);
            ms8_reg <= ms7_reg;
            side8_reg <= side7_reg;
        end
    end

    assign out_valid = v_reg[7];
    assign num_u = num_u_reg;
    assign num_v = num_v_reg;
    assign den = ms8_reg;
    assign side = side8_reg;

endmodule

### rtl/cpp_div.sv
// cpp_div: pipelined restoring divider, an overflow check stage then one quotient bit per stage,
// quotient capped at two to the QUOT_BITS; uses cpp_pkg
module cpp_div #(
    parameter int SW = 39,
    parameter int NW = 70
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [NW-1:0]                 num,
    input  logic [SW-1:0]                 den,
    output logic [cpp_pkg::QUOT_BITS:0]   quot
);

    localparam int QB = cpp_pkg::QUOT_BITS;

    logic [SW-1:0] rem_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic [SW-1:0] den_reg [0:QB];
    logic          ovf_reg [0:QB];

    logic [SW-1:0] rem_init;

    assign rem_init = SW'(num[NW-1:QB]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_init;
            low_reg[0] <= num[QB-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= (rem_init >= den);
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [SW:0] trial;
        logic        ge;

        assign trial = {rem_reg[k-1], low_reg[k-1][QB-1]};
        assign ge = (trial >= (SW+1)'(den_reg[k-1]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? SW'(trial - (SW+1)'(den_reg[k-1])) : trial[SW-1:0];
                low_reg[k] <= {low_reg[k-1][QB-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quot = ovf_reg[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_reg[QB]};

endmodule

### rtl/camera_perspective_projection.sv
// camera_perspective_projection: top level, config registers, divider lanes,
// sideband delay and saturating output stage; uses cpp_pkg, cpp_geom, cpp_div
//
//  channel   direction  handshake             word
//  input     in         in_valid / in_stall    world_x, world_y, world_z
//  output    out        out_valid / out_stall  screen_u, screen_v, plane_depth, invalid
//  config    in         cfg_wr_en              cfg_index, cfg_data
//
// one word per cycle unless the output stalls; 8 geometry stages,
// 34 divider stages (an overflow check, then one quotient bit each), 1 output register
// a stalled output word freezes the whole pipeline; in_stall follows it
// reset clears all valid bits and loads the camera defaults
module camera_perspective_projection #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  world_x,
    input  logic signed [31:0]  world_y,
    input  logic signed [31:0]  world_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  screen_u,
    output logic signed [31:0]  screen_v,
    output logic signed [31:0]  plane_depth,
    output logic                invalid
);

    localparam int QB = cpp_pkg::QUOT_BITS;
    localparam int HW = 50 - TRIG_FRAC_BITS;
    localparam int QW = 16 + HW;
    localparam int SW = QW + 1 - TRIG_FRAC_BITS;
    localparam int NW = 31 + SW;
    localparam int DLY = QB + 1;
    localparam logic [QB:0] NEG_LIMIT = {{(QB-31){1'b0}}, 1'b1, 31'b0};

    typedef struct packed {
        logic [31:0] val;
        logic        flag;
    } lane_t;

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [30:0]        dist_reg;
    logic signed [15:0] cy_reg, sy_reg, cp_reg, sp_reg;

    logic               en;
    logic               g_valid;
    logic [NW-1:0]      num_u, num_v;
    logic [SW-1:0]      den;
    cpp_pkg::side_t     g_side;
    logic [QB:0]        quot_u, quot_v;

    logic [DLY-1:0]     vdly_reg;
    cpp_pkg::side_t     sdly_reg [0:DLY-1];

    logic               out_valid_reg;
    logic [31:0]        screen_u_reg, screen_v_reg, plane_depth_reg;
    logic               invalid_reg;

    cpp_pkg::side_t     fs;
    lane_t              lu, lv;

    function automatic lane_t lane_result(input logic [QB:0] q, input logic num_neg,
                                          input logic num_zero, input logic s_neg,
                                          input logic s_zero, input logic d_zero);
        lane_t r;
        logic  neg;
        neg = num_neg ^ s_neg;
        r.flag = 1'b0;
        priority if (num_zero || d_zero)
        begin
            r.val = '0;
        end
        else if (s_zero)
        begin
            r.val = num_neg ? 32'h8000_0000 : 32'h7fff_ffff;
            r.flag = 1'b1;
        end
        else if (neg)
        begin
            if (q > NEG_LIMIT)
            begin
                r.val = 32'h8000_0000;
                r.flag = 1'b1;
            end
            else
            begin
                r.val = 32'(-q);
            end
        end
        else if (|q[QB:31])
        begin
            r.val = 32'h7fff_ffff;
            r.flag = 1'b1;
        end
        else
        begin
            r.val = q[31:0];
        end
        return r;
    endfunction

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            dist_reg  <= 31'd458752;
            cy_reg    <= 16'sd16384;
            sy_reg    <= '0;
            cp_reg    <= 16'sd16384;
            sp_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cpp_pkg::REG_CAM_POS_X:     cam_x_reg <= cfg_data;
                cpp_pkg::REG_CAM_POS_Y:     cam_y_reg <= cfg_data;
                cpp_pkg::REG_CAM_POS_Z:     cam_z_reg <= cfg_data;
                cpp_pkg::REG_VIEW_DISTANCE: dist_reg  <= cfg_data[30:0];
                cpp_pkg::REG_COS_YAW:       cy_reg    <= cfg_data[15:0];
                cpp_pkg::REG_SIN_YAW:       sy_reg    <= cfg_data[15:0];
                cpp_pkg::REG_COS_PITCH:     cp_reg    <= cfg_data[15:0];
                cpp_pkg::REG_SIN_PITCH:     sp_reg    <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    cpp_geom #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_geom (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(in_valid),
        .world_x(world_x),
        .world_y(world_y),
        .world_z(world_z),
        .cam_x(cam_x_reg),
        .cam_y(cam_y_reg),
        .cam_z(cam_z_reg),
        .view_dist(dist_reg),
        .cy(cy_reg),
        .sy(sy_reg),
        .cp(cp_reg),
        .sp(sp_reg),
        .out_valid(g_valid),
        .num_u(num_u),
        .num_v(num_v),
        .den(den),
        .side(g_side)
    );

    cpp_div #(
        .SW(SW),
        .NW(NW)
    ) u_div_u (
        .clk(clk),
        .en(en),
        .num(num_u),
        .den(den),
        .quot(quot_u)
    );

    cpp_div #(
        .SW(SW),
        .NW(NW)
    ) u_div_v (
        .clk(clk),
        .en(en),
        .num(num_v),
        .den(den),
        .quot(quot_v)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vdly_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vdly_reg <= {vdly_reg[DLY-2:0], g_valid};
            out_valid_reg <= vdly_reg[DLY-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sdly_reg[0] <= g_side;
            for (int i = 1; i < DLY; i++)
            begin
                sdly_reg[i] <= sdly_reg[i-1];
            end
        end
    end

    always_comb
    begin
        fs = sdly_reg[DLY-1];
        lu = lane_result(quot_u, fs.u_neg, fs.u_zero, fs.s_neg, fs.s_zero, fs.d_zero);
        lv = lane_result(quot_v, fs.v_neg, fs.v_zero, fs.s_neg, fs.s_zero, fs.d_zero);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            screen_u_reg <= lu.val;
            screen_v_reg <= lv.val;
            plane_depth_reg <= fs.depth;
            invalid_reg <= lu.flag | lv.flag | fs.depth_ovf | fs.s_zero;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_u = screen_u_reg;
    assign screen_v = screen_v_reg;
    assign plane_depth = plane_depth_reg;
    assign invalid = invalid_reg;

endmodule
